### hw/rtl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

   localparam int FUNC_W       = 3;
   localparam int POS_W        = 7;
   localparam int DATA_W       = 32;
   localparam int STATUS_W     = 2;
   localparam int CAPACITY_DEF = 64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 3'd0,
      FUNC_DELETE = 3'd1,
      FUNC_GET    = 3'd2,
      FUNC_SIZE   = 3'd3,
      FUNC_DUMP   = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

endpackage

### hw/rtl/positional_list_engine_top.sv
`timescale 1ns / 1ps

// channel   ports                                            handshake
// --------  -----------------------------------------------  --------------------------
// request   req_func, req_position, req_value                start high while busy low
// response  rsp_status, rsp_data, rsp_last                   rsp_valid, one cycle each
//
// get, size, errors and insert or delete at the tail: busy stays low, and the registered
// result is shown in the cycle after the item is taken.
// insert at p: busy in S_INS_RD, S_INS_WAIT, S_INS_PUT; delete at p: S_DEL_RD, S_DEL_WAIT.
// one entry moves per cycle through the single-port-read, single-port-write list memory.
// dump: count results on consecutive cycles, one memory read each.
// reset (synchronous) empties the list; memory contents are not cleared.
// the receiver cannot stall: every result is taken in the cycle it is shown.

module positional_list_engine_top
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_data,
   output logic                       rsp_last
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WAIT,
      S_INS_PUT,
      S_DEL_RD,
      S_DEL_WAIT,
      S_DUMP
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       rd_addr_ff, rd_addr_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic                shift_vld_ff, shift_vld_in;
   logic [AW-1:0]       shift_addr_ff, shift_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_mem_ff, rsp_mem_in;

   logic [DATA_W-1:0]   mem [CAPACITY];
   logic [DATA_W-1:0]   mem_rdata_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [DATA_W-1:0]   mem_wdata;
   logic [AW-1:0]       mem_raddr;

   logic                accept;
   logic [POS_W-1:0]    count_pos;
   logic [AW-1:0]       count_m1;
   logic [AW-1:0]       req_addr;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign count_pos = POS_W'(count_ff);
   assign count_m1  = AW'(count_ff - 1'b1);
   assign req_addr  = AW'(req_position);

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;
   // get and dump data comes straight from the registered memory read
   assign rsp_data   = rsp_mem_ff ? mem_rdata_ff : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_addr_in    = rd_addr_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      shift_vld_in  = 1'b0;
      shift_addr_in = shift_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;
      rsp_mem_in    = 1'b0;

      mem_raddr = (req_func == FUNC_DUMP) ? '0 : req_addr;
      // a pending shifted entry always owns the write port
      mem_we    = shift_vld_ff;
      mem_waddr = shift_addr_ff;
      mem_wdata = mem_rdata_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               priority case (req_func)
                  FUNC_INSERT: begin
                     if (req_position > count_pos) begin
                        rsp_status_in = ST_RANGE;
                     end else if (count_ff >= CW'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else if (req_position == count_pos) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_addr;
                        mem_wdata = req_value;
                        count_in  = count_ff + 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        pos_in       = req_addr;
                        value_in     = req_value;
                        rd_addr_in   = count_m1;
                        state_in     = S_INS_RD;
                     end
                  end
                  FUNC_DELETE: begin
                     if (req_position >= count_pos) begin
                        rsp_status_in = ST_RANGE;
                     end else if (req_position == POS_W'(count_ff - 1'b1)) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_addr_in   = AW'(req_addr + 1'b1);
                        state_in     = S_DEL_RD;
                     end
                  end
                  FUNC_GET: begin
                     if (req_position >= count_pos) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        rsp_mem_in = 1'b1;
                     end
                  end
                  FUNC_SIZE: begin
                     rsp_data_in = DATA_W'(count_ff);
                  end
                  FUNC_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_mem_in = 1'b1;
                        if (count_ff != CW'(1)) begin
                           rsp_last_in = 1'b0;
                           rd_addr_in  = AW'(1);
                           state_in    = S_DUMP;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            // walk down from the tail, each entry lands one slot higher next cycle
            mem_raddr     = rd_addr_ff;
            shift_vld_in  = 1'b1;
            shift_addr_in = AW'(rd_addr_ff + 1'b1);
            if (rd_addr_ff == pos_ff) begin
               state_in = S_INS_WAIT;
            end else begin
               rd_addr_in = rd_addr_ff - 1'b1;
            end
         end
         S_INS_WAIT: begin
            state_in = S_INS_PUT;
         end
         S_INS_PUT: begin
            mem_we       = 1'b1;
            mem_waddr    = pos_ff;
            mem_wdata    = value_ff;
            count_in     = count_ff + 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_DEL_RD: begin
            mem_raddr     = rd_addr_ff;
            shift_vld_in  = 1'b1;
            shift_addr_in = rd_addr_ff - 1'b1;
            if (rd_addr_ff == count_m1) begin
               state_in = S_DEL_WAIT;
            end else begin
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         S_DEL_WAIT: begin
            count_in     = count_ff - 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_DUMP: begin
            mem_raddr    = rd_addr_ff;
            rsp_valid_in = 1'b1;
            rsp_mem_in   = 1'b1;
            if (rd_addr_ff == count_m1) begin
               state_in = S_IDLE;
            end else begin
               rsp_last_in = 1'b0;
               rd_addr_in  = rd_addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         shift_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_mem_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         shift_vld_ff <= shift_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_mem_ff   <= rsp_mem_in;
      end
      rd_addr_ff    <= rd_addr_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      shift_addr_ff <= shift_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
